FILE: rtl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache core.
// Used by the channel interfaces and the core module of the block.
`timescale 1ns / 1ps

package salc_pkg;

  // Geometry of the line store.
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // Field widths fixed by the interface.
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 64;
  localparam int OUTCOME_W = 2;
  localparam int COUNT_W   = 32;
  localparam int TAG_W     = 64;
  localparam int STAMP_W   = 32;
  localparam int SB_W      = 3;
  localparam int BB_W      = 6;
  localparam int WAYS_W    = 4;
  localparam int SHIFT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // Access outcomes.
  localparam logic [OUTCOME_W-1:0] OC_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OC_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OC_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;
    logic [COUNT_W-1:0]   eviction_total;
    logic                 last;
  } res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

FILE: rtl/salc_in_if.sv
// Request channel carrying one cache access request.
// Depends on salc_pkg for field widths.
`timescale 1ns / 1ps

interface salc_in_if;
  logic                         valid;
  logic                         ready;
  logic [salc_pkg::KIND_W-1:0]  kind;
  logic [salc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

FILE: rtl/salc_out_if.sv
// Result channel carrying one access outcome and the running totals.
// Depends on salc_pkg for field widths.
`timescale 1ns / 1ps

interface salc_out_if;
  logic                           valid;
  logic                           ready;
  logic [salc_pkg::OUTCOME_W-1:0] outcome;
  logic [salc_pkg::COUNT_W-1:0]   hit_total;
  logic [salc_pkg::COUNT_W-1:0]   miss_total;
  logic [salc_pkg::COUNT_W-1:0]   eviction_total;
  logic                           last;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, output last, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, input last, output ready);
endinterface

FILE: rtl/salc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on salc_pkg for field widths.
`timescale 1ns / 1ps

interface salc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [salc_pkg::CFG_IDX_W-1:0]  index;
  logic [salc_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/salc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/set_associative_lru_cache_sim_core.sv
// An accepted load, store or modify request has its set read, then the write-back, which
// pushes its result into the result queue; a modify yields both of its results from the one
// write-back. No new request is taken until the write-back is done; a request of the unused
// kind takes no lookup. Reset is synchronous: control, counters and the per-set valid bits clear
// at once, so no clearing pass is needed. Depends on salc_pkg, the channel interfaces and salc_ram.
`timescale 1ns / 1ps

module set_associative_lru_cache_sim_core (
  input  logic        clk,
  input  logic        rst_n,
  salc_in_if.sink     in_chan,
  salc_out_if.source  out_chan,
  salc_cfg_if.sink    cfg_chan
);

  // Result queue of four entries. A request is taken only while two slots are
  // sure to be free when its lookup completes.
  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_r, state_nxt;

  // Configuration registers.
  logic [salc_pkg::SB_W-1:0]   set_bits_r;
  logic [salc_pkg::BB_W-1:0]   block_bits_r;
  logic [salc_pkg::WAYS_W-1:0] ways_r;

  // Request held across the lookup cycle.
  logic [salc_pkg::TAG_W-1:0] tag_r;
  logic [salc_pkg::SET_W-1:0] set_r;
  logic                       mod_r;

  // Global access clock and saturating totals.
  logic [salc_pkg::STAMP_W-1:0] clock_r, clock_nxt;
  logic [salc_pkg::COUNT_W-1:0] hit_r, miss_r, evict_r;
  logic [salc_pkg::COUNT_W-1:0] hit1, miss1, evict1;

  // One bit per set: the row has been written since reset. A row that has
  // never been written reads as a row of invalid lines, so the RAM itself
  // needs no clearing.
  logic [salc_pkg::NUM_SETS-1:0] row_seen_r;

  // Result queue.
  salc_pkg::res_t     q_r [QDEPTH];
  logic [Q_AW-1:0]    wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r;

  // ---------------------------------------------------------------------
  // Address decode for an incoming request, done before the set is read.
  // ---------------------------------------------------------------------
  logic [salc_pkg::SB_W-1:0]    eff_sb;
  logic [salc_pkg::SHIFT_W-1:0] tshift;
  logic [salc_pkg::TAG_W-1:0]   in_tag;
  logic [salc_pkg::ADDR_W-1:0]  shifted;
  logic [salc_pkg::SET_W-1:0]   set_mask;
  logic [salc_pkg::SET_W-1:0]   in_set;
  logic                         in_ready;
  logic                         accept;
  logic                         do_access;

  always_comb begin
    eff_sb = (32'(set_bits_r) > salc_pkg::MAX_SET_BITS) ?
             salc_pkg::SB_W'(salc_pkg::MAX_SET_BITS) : set_bits_r;
    tshift = salc_pkg::SHIFT_W'(block_bits_r) + salc_pkg::SHIFT_W'(eff_sb);
    in_tag = (tshift >= salc_pkg::SHIFT_W'(64)) ? '0 : (in_chan.address >> tshift);
    shifted = in_chan.address >> block_bits_r;
    for (int i = 0; i < salc_pkg::SET_W; i++) begin
      set_mask[i] = (i < 32'(eff_sb));
    end
    in_set = shifted[salc_pkg::SET_W-1:0] & set_mask;
  end

  assign in_ready  = (state_r == ST_IDLE) && (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign accept    = in_chan.valid && in_ready;
  assign do_access = accept && (in_chan.kind != salc_pkg::KIND_NONE);
  assign in_chan.ready = in_ready;

  // ---------------------------------------------------------------------
  // Line store: one row per set, all ways side by side.
  // ---------------------------------------------------------------------
  salc_pkg::row_t rd_row, wr_row, row;
  logic           wr_en;

  salc_ram #(
    .WIDTH ($bits(salc_pkg::row_t)),
    .DEPTH (salc_pkg::NUM_SETS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (set_r),
    .wr_data (wr_row),
    .rd_en   (do_access),
    .rd_addr (in_set),
    .rd_data (rd_row)
  );

  // ---------------------------------------------------------------------
  // Lookup: tag match, first empty way, oldest way, then the write-back.
  // ---------------------------------------------------------------------
  logic [salc_pkg::MAX_WAYS-1:0] in_use, line_ok, hit_vec;
  logic [salc_pkg::WAY_W-1:0]    hit_w, empty_w, old_w, pick;
  logic                          hit_found, empty_found;
  logic [salc_pkg::STAMP_W-1:0]  age, best_age;
  logic [salc_pkg::OUTCOME_W-1:0] outcome;
  salc_pkg::res_t                res0, res1;

  always_comb begin
    row = rd_row;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      // Ways beyond the configured count are ignored but kept intact.
      in_use[w]  = (w == 0) || (32'(ways_r) > w);
      line_ok[w] = row_seen_r[set_r] && rd_row[w].valid;
      row[w].valid = line_ok[w];
      hit_vec[w] = in_use[w] && line_ok[w] && (rd_row[w].tag == tag_r);
    end

    hit_found = 1'b0;
    hit_w     = '0;
    empty_found = 1'b0;
    empty_w   = '0;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      if (!hit_found && hit_vec[w]) begin
        hit_found = 1'b1;
        hit_w     = salc_pkg::WAY_W'(w);
      end
      if (!empty_found && in_use[w] && !line_ok[w]) begin
        empty_found = 1'b1;
        empty_w     = salc_pkg::WAY_W'(w);
      end
    end

    // Oldest line by modular age; the lowest way wins a tie.
    best_age = '0;
    old_w    = '0;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      age = clock_r - rd_row[w].stamp;
      if (in_use[w] && (w == 0 || age > best_age)) begin
        best_age = age;
        old_w    = salc_pkg::WAY_W'(w);
      end
    end

    if (hit_found) begin
      outcome = salc_pkg::OC_HIT;
      pick    = hit_w;
    end else if (empty_found) begin
      outcome = salc_pkg::OC_FILL;
      pick    = empty_w;
    end else begin
      outcome = salc_pkg::OC_EVICT;
      pick    = old_w;
    end

    hit1   = hit_found ? salc_pkg::sat_inc(hit_r) : hit_r;
    miss1  = hit_found ? miss_r : salc_pkg::sat_inc(miss_r);
    evict1 = (!hit_found && !empty_found) ? salc_pkg::sat_inc(evict_r) : evict_r;

    // The second access of a modify always hits the line just touched, so
    // the write-back carries its stamp directly.
    wr_row = row;
    for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
      if (32'(pick) == w) begin
        wr_row[w].valid = 1'b1;
        wr_row[w].tag   = tag_r;
        wr_row[w].stamp = mod_r ? clock_r + salc_pkg::STAMP_W'(1) : clock_r;
      end
    end

    clock_nxt = clock_r + (mod_r ? salc_pkg::STAMP_W'(2) : salc_pkg::STAMP_W'(1));

    res0.outcome        = outcome;
    res0.hit_total      = hit1;
    res0.miss_total     = miss1;
    res0.eviction_total = evict1;
    res0.last           = !mod_r;

    res1.outcome        = salc_pkg::OC_HIT;
    res1.hit_total      = salc_pkg::sat_inc(hit1);
    res1.miss_total     = miss1;
    res1.eviction_total = evict1;
    res1.last           = 1'b1;
  end

  assign wr_en = (state_r == ST_LOOK);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_access) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  logic pop;
  logic [QCNT_W-1:0] push_n;

  assign pop    = out_chan.valid && out_chan.ready;
  assign push_n = wr_en ? (mod_r ? QCNT_W'(2) : QCNT_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= salc_pkg::WAYS_W'(1);
      clock_r      <= '0;
      hit_r        <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      row_seen_r   <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          salc_pkg::REG_SET_BITS:   set_bits_r   <= cfg_chan.data[salc_pkg::SB_W-1:0];
          salc_pkg::REG_BLOCK_BITS: block_bits_r <= cfg_chan.data[salc_pkg::BB_W-1:0];
          salc_pkg::REG_WAYS:       ways_r       <= cfg_chan.data[salc_pkg::WAYS_W-1:0];
          default: ;
        endcase
      end

      if (wr_en) begin
        clock_r           <= clock_nxt;
        hit_r             <= mod_r ? res1.hit_total : hit1;
        miss_r            <= miss1;
        evict_r           <= evict1;
        row_seen_r[set_r] <= 1'b1;
      end

      wp_r  <= wp_r + push_n[Q_AW-1:0];
      rp_r  <= rp_r + (pop ? Q_AW'(1) : Q_AW'(0));
      cnt_r <= cnt_r + push_n - (pop ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (do_access) begin
      tag_r <= in_tag;
      set_r <= in_set;
      mod_r <= (in_chan.kind == salc_pkg::KIND_MODIFY);
    end
    if (wr_en) begin
      q_r[wp_r] <= res0;
      if (mod_r) begin
        q_r[wp_r + Q_AW'(1)] <= res1;
      end
    end
  end

  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid          = (cnt_r != '0);
  assign out_chan.outcome        = q_r[rp_r].outcome;
  assign out_chan.hit_total      = q_r[rp_r].hit_total;
  assign out_chan.miss_total     = q_r[rp_r].miss_total;
  assign out_chan.eviction_total = q_r[rp_r].eviction_total;
  assign out_chan.last           = q_r[rp_r].last;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_no_take_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> !in_chan.ready)
    else $error("request taken during lookup");

  a_access_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.kind != salc_pkg::KIND_NONE))
      |=> (state_r == ST_LOOK))
    else $error("accepted access did not start a lookup");

  a_clock_moves_on_access: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOOK) |=> $stable(clock_r))
    else $error("access clock moved without an access");

  a_lookup_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |=> out_chan.valid)
    else $error("lookup left no result");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for set_associative_lru_cache_sim_core: a behavioural cache model
// predicts outcome and running totals for every accepted request; results are checked in order.
// Depends on salc_pkg, the three channel interfaces and the core itself.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_LINES  = salc_pkg::NUM_SETS * salc_pkg::MAX_WAYS;
  localparam int TAG_POOL   = 12;
  // Cycles allowed with no handshake on any channel before the run is abandoned. The limit is
  // well above the long receiver hold below, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  // Index 3 selects no register; a write to it must leave the configuration alone.
  localparam logic [salc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Receiver behaviour: always ready, mostly ready, or mostly stalled.
  localparam int RX_OPEN    = 0;
  localparam int RX_BUSY    = 1;
  localparam int RX_CHOKED  = 2;

  logic clk = 1'b0;
  logic rst_n;

  salc_in_if  in_if ();
  salc_out_if out_if ();
  salc_cfg_if cfg_if ();

  set_associative_lru_cache_sim_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache. Every accepted request is replayed here and the
  // results it ought to produce are queued for the checker.
  // ---------------------------------------------------------------------------
  logic [salc_pkg::SB_W-1:0]   set_bits_reg   = '0;
  logic [salc_pkg::BB_W-1:0]   block_bits_reg = '0;
  logic [salc_pkg::WAYS_W-1:0] ways_reg       = 4'd1;

  bit                           shadow_valid [NUM_LINES];
  logic [salc_pkg::TAG_W-1:0]   shadow_tag   [NUM_LINES];
  logic [salc_pkg::STAMP_W-1:0] shadow_stamp [NUM_LINES];
  logic [salc_pkg::STAMP_W-1:0] shadow_clock = '0;
  logic [salc_pkg::COUNT_W-1:0] hits         = '0;
  logic [salc_pkg::COUNT_W-1:0] misses       = '0;
  logic [salc_pkg::COUNT_W-1:0] evictions    = '0;

  salc_pkg::res_t expected_results [$];
  salc_pkg::res_t oldest;
  int   failures = 0;

  // Tags in play for the current phase; reusing a handful is what produces hits and
  // conflict evictions rather than a stream of cold misses.
  logic [salc_pkg::ADDR_W-1:0] tag_pool [TAG_POOL];

  function automatic logic [salc_pkg::COUNT_W-1:0] count_up(
      input logic [salc_pkg::COUNT_W-1:0] v);
    return (v == {salc_pkg::COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Out-of-range register values are clamped rather than rejected.
  function automatic int unsigned eff_set_bits();
    return (set_bits_reg > salc_pkg::MAX_SET_BITS) ? salc_pkg::MAX_SET_BITS : set_bits_reg;
  endfunction

  function automatic int unsigned eff_ways();
    if (ways_reg == 0) return 1;
    return (ways_reg > salc_pkg::MAX_WAYS) ? salc_pkg::MAX_WAYS : ways_reg;
  endfunction

  // One lookup: hit refreshes the stamp, a miss takes the lowest empty way or else the
  // way with the greatest modular age (lowest way on a tie).
  function automatic logic [salc_pkg::OUTCOME_W-1:0] cache_access(
      input logic [salc_pkg::ADDR_W-1:0] addr);
    int unsigned                    sb, nw, shift, base, pick;
    logic [salc_pkg::TAG_W-1:0]     tag;
    logic [salc_pkg::STAMP_W-1:0]   age, oldest_age;
    logic [salc_pkg::OUTCOME_W-1:0] oc;
    bit                             found;
    sb    = eff_set_bits();
    nw    = eff_ways();
    shift = block_bits_reg + sb;
    // A shift of 64 or more leaves no tag bits at all.
    tag   = (shift >= 64) ? '0 : addr >> shift;
    base  = int'((addr >> block_bits_reg) & ((64'd1 << sb) - 64'd1)) * salc_pkg::MAX_WAYS;
    pick  = 0;
    found = 1'b0;
    oldest_age = '0;
    for (int w = 0; w < nw; w++) begin
      if (!found && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
        pick  = w;
        found = 1'b1;
      end
    end
    if (found) begin
      hits = count_up(hits);
      oc   = salc_pkg::OC_HIT;
    end else begin
      misses = count_up(misses);
      for (int w = 0; w < nw; w++) begin
        if (!found && !shadow_valid[base+w]) begin
          pick  = w;
          found = 1'b1;
        end
      end
      if (found) begin
        oc = salc_pkg::OC_FILL;
      end else begin
        evictions = count_up(evictions);
        oc = salc_pkg::OC_EVICT;
        for (int w = 0; w < nw; w++) begin
          age = shadow_clock - shadow_stamp[base+w];
          if (w == 0 || age > oldest_age) begin
            oldest_age = age;
            pick       = w;
          end
        end
      end
      shadow_valid[base+pick] = 1'b1;
      shadow_tag[base+pick]   = tag;
    end
    shadow_stamp[base+pick] = shadow_clock;
    shadow_clock = shadow_clock + 1'b1;
    return oc;
  endfunction

  function automatic void queue_result(input logic [salc_pkg::OUTCOME_W-1:0] oc,
                                       input logic fin);
    salc_pkg::res_t r;
    r.outcome        = oc;
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evictions;
    r.last           = fin;
    expected_results.push_back(r);
  endfunction

  // A modify is two lookups of the same address; only the second carries last.
  function automatic void predict_request(input logic [salc_pkg::KIND_W-1:0] k,
                                          input logic [salc_pkg::ADDR_W-1:0] a);
    if (k == salc_pkg::KIND_NONE) return;
    queue_result(cache_access(a), k != salc_pkg::KIND_MODIFY);
    if (k == salc_pkg::KIND_MODIFY) queue_result(cache_access(a), 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Request sender. Requests go out in bursts of random length, separated by
  // random gaps; valid is only lowered when a gap actually follows, so it is
  // never dropped and raised within the same time step.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_request(input logic [salc_pkg::KIND_W-1:0] k,
                              input logic [salc_pkg::ADDR_W-1:0] a);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= k;
    in_if.address <= a;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_request(k, a);
    burst_left--;
  endtask

  // Waits until every expected result has been seen, then a few more cycles in case an
  // unused-kind request, which yields nothing, is still passing through.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [salc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [salc_pkg::CFG_DAT_W-1:0] val);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      salc_pkg::REG_SET_BITS:   set_bits_reg   = val[salc_pkg::SB_W-1:0];
      salc_pkg::REG_BLOCK_BITS: block_bits_reg = val[salc_pkg::BB_W-1:0];
      salc_pkg::REG_WAYS:       ways_reg       = val[salc_pkg::WAYS_W-1:0];
      default: ;
    endcase
  endtask

  // The upper data bits beyond each register's width are filled with noise; the
  // block must ignore them.
  task automatic configure(input int unsigned sb, input int unsigned bb, input int unsigned ways);
    logic [salc_pkg::CFG_DAT_W-1:0] val;
    val = salc_pkg::CFG_DAT_W'($urandom);
    val[salc_pkg::SB_W-1:0] = salc_pkg::SB_W'(sb);
    write_reg(salc_pkg::REG_SET_BITS, val);
    val = salc_pkg::CFG_DAT_W'($urandom);
    val[salc_pkg::BB_W-1:0] = salc_pkg::BB_W'(bb);
    write_reg(salc_pkg::REG_BLOCK_BITS, val);
    val = salc_pkg::CFG_DAT_W'($urandom);
    val[salc_pkg::WAYS_W-1:0] = salc_pkg::WAYS_W'(ways);
    write_reg(salc_pkg::REG_WAYS, val);
  endtask

  task automatic refresh_tag_pool();
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
  endtask

  // Builds an address from a pooled tag, one of the first few sets and a random offset,
  // so that the same lines come round again under the current geometry.
  function automatic logic [salc_pkg::ADDR_W-1:0] pick_address(input int unsigned n_tags,
                                                               input int unsigned n_sets);
    int unsigned                 sb, shift;
    logic [salc_pkg::ADDR_W-1:0] offs, setf, tagf;
    sb    = eff_set_bits();
    shift = block_bits_reg + sb;
    offs  = {$urandom, $urandom} & ((64'd1 << block_bits_reg) - 64'd1);
    setf  = (64'($urandom_range(0, n_sets - 1)) & ((64'd1 << sb) - 64'd1)) << block_bits_reg;
    tagf  = (shift >= 64) ? '0 : tag_pool[$urandom_range(0, n_tags - 1)] << shift;
    return tagf | setf | offs;
  endfunction

  function automatic logic [salc_pkg::KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return salc_pkg::KIND_NONE;
    if (r < 8)  return salc_pkg::KIND_LOAD;
    if (r < 14) return salc_pkg::KIND_STORE;
    return salc_pkg::KIND_MODIFY;
  endfunction

  // Mostly well-formed reuse of the pool, with some fully random addresses as noise.
  task automatic send_random(input int unsigned count, input int unsigned n_tags,
                             input int unsigned n_sets);
    logic [salc_pkg::ADDR_W-1:0] a;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
      else a = pick_address(n_tags, n_sets);
      send_request(pick_kind(), a);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: one set, no offset bits, a single way. Covers hit, fill, eviction,
  // a modify whose second access hits, the unused kind and the all-ones address.
  task automatic test_reset_defaults();
    send_request(salc_pkg::KIND_LOAD,   64'd0);
    send_request(salc_pkg::KIND_STORE,  64'd0);
    send_request(salc_pkg::KIND_MODIFY, 64'd0);
    send_request(salc_pkg::KIND_LOAD,   64'd1);
    send_request(salc_pkg::KIND_MODIFY, 64'd2);
    send_request(salc_pkg::KIND_NONE,   {salc_pkg::ADDR_W{1'b1}});
    send_request(salc_pkg::KIND_LOAD,   {salc_pkg::ADDR_W{1'b1}});
    send_request(salc_pkg::KIND_STORE,  {salc_pkg::ADDR_W{1'b1}});
  endtask

  // Eight ways in one set: seven loads fill it beside the line kept from the previous test; a
  // new store and load then evict the oldest lines in turn, and a modify of the stored address hits.
  task automatic test_lru_order();
    configure(0, 0, salc_pkg::MAX_WAYS);
    for (int t = 1; t < salc_pkg::MAX_WAYS; t++) begin
      send_request(salc_pkg::KIND_LOAD, salc_pkg::ADDR_W'(t + 8));
    end
    send_request(salc_pkg::KIND_STORE,  64'd2);
    send_request(salc_pkg::KIND_LOAD,   64'd100);
    send_request(salc_pkg::KIND_MODIFY, 64'd2);
  endtask

  // Clamping of the set and way counts, and the tag shift reaching 64 bits.
  task automatic test_clamps_and_wide_tag();
    configure(7, 58, 1);
    send_request(salc_pkg::KIND_LOAD, {salc_pkg::ADDR_W{1'b1}});
    send_request(salc_pkg::KIND_LOAD, 64'hFC00_0000_0000_0000);
    configure(0, 63, 0);
    send_request(salc_pkg::KIND_LOAD,   64'h8000_0000_0000_0000);
    send_request(salc_pkg::KIND_STORE,  64'h7FFF_FFFF_FFFF_FFFF);
    configure(3, 6, 15);
    send_request(salc_pkg::KIND_MODIFY, 64'h0000_0000_0000_01C0);
  endtask

  // Narrowing the way count hides lines without losing them; widening again must
  // find them still there. A write to the unused index must change nothing.
  task automatic test_reconfig_keeps_lines();
    refresh_tag_pool();
    configure(1, 2, 8);
    send_random(24, 10, 2);
    write_reg(REG_UNUSED, salc_pkg::CFG_DAT_W'($urandom));
    configure(1, 2, 2);
    send_random(20, 10, 2);
    configure(1, 2, 8);
    send_random(20, 10, 2);
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the core
  // has to back up and hold its input.
  logic hold_req = 1'b0;

  task automatic test_backpressure();
    refresh_tag_pool();
    configure(2, 3, 4);
    hold_req = 1'b1;
    send_random(60, 7, 4);
  endtask

  // Random phases: the extremes first, then random geometries with small block sizes
  // favoured so that sets and offsets both vary.
  task automatic test_random_mix();
    int unsigned sb, bb, ways;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sb = 0; bb = 0;  ways = 1;  end
        1: begin sb = 6; bb = 5;  ways = 8;  end
        2: begin sb = 7; bb = 63; ways = 15; end
        3: begin sb = 4; bb = 58; ways = 0;  end
        default: begin
          sb   = $urandom_range(0, 7);
          bb   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
          ways = $urandom_range(0, 15);
        end
      endcase
      refresh_tag_pool();
      configure(sb, bb, ways);
      send_random(130, eff_ways() + $urandom_range(1, 4), $urandom_range(1, 4));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.kind    <= salc_pkg::KIND_LOAD;
    in_if.address <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= salc_pkg::REG_SET_BITS;
    cfg_if.data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_lru_order();
    test_clamps_and_wide_tag();
    test_reconfig_keeps_lines();
    test_backpressure();
    test_random_mix();

    // All requests are in; let the last results come out and give any stray
    // result time to show itself.
    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: alternates between stretches of constant readiness, light and heavy
  // stalling, and on request holds ready low for a long count of its own.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(RX_OPEN, RX_CHOKED);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: out_if.ready <= 1'b1;
          RX_BUSY: out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: outcome %0d, last %0d", out_if.outcome, out_if.last);
        failures++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_if.outcome !== oldest.outcome) begin
          $error("outcome: expected %0d, got %0d", oldest.outcome, out_if.outcome);
          failures++;
        end
        if (out_if.hit_total !== oldest.hit_total) begin
          $error("hit_total: expected %0d, got %0d", oldest.hit_total, out_if.hit_total);
          failures++;
        end
        if (out_if.miss_total !== oldest.miss_total) begin
          $error("miss_total: expected %0d, got %0d", oldest.miss_total, out_if.miss_total);
          failures++;
        end
        if (out_if.eviction_total !== oldest.eviction_total) begin
          $error("eviction_total: expected %0d, got %0d",
                 oldest.eviction_total, out_if.eviction_total);
          failures++;
        end
        if (out_if.last !== oldest.last) begin
          $error("last: expected %0d, got %0d", oldest.last, out_if.last);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel resets the count of quiet cycles.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/salc_pkg.sv
rtl/salc_in_if.sv
rtl/salc_out_if.sv
rtl/salc_cfg_if.sv
rtl/salc_ram.sv
rtl/set_associative_lru_cache_sim_core.sv
dv/testbench.sv
